### rtl/animation_progress_timeline_assert.svh
// Assertion macros for the animation progress timeline
`ifndef ANIMATION_PROGRESS_TIMELINE_ASSERT_SVH
`define ANIMATION_PROGRESS_TIMELINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define APT_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
`define APT_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);
`else
`define APT_ASSERT(label, cond, msg)
`define APT_ASSERT_IMPL(label, pre, post, msg)
`endif
`endif

### rtl/aptl_pkg.sv
// Shared types and constants of the animation progress timeline
package aptl_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int PROG_W     = FRAC_BITS + 1;
  localparam int ELAPSED_W  = 16;
  localparam int DUR_W      = 20;
  localparam int QUO_W      = ELAPSED_W + FRAC_BITS;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [PROG_W-1:0] PROG_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [PROG_W-1:0] PROG_ZERO = '0;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_START  = 2'd1,
    CMD_PAUSE  = 2'd2,
    CMD_REWIND = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DURATION = 2'd0,
    REG_BACKWARD = 2'd1,
    REG_LOOP     = 2'd2,
    REG_ANIM_ON  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [ELAPSED_W-1:0] elapsed_ms;
  } in_req_t;

  typedef struct packed {
    logic [PROG_W-1:0] progress;
    logic              frame_event;
    logic              finished;
    logic              started;
    logic              paused;
    logic              running;
  } out_rsp_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### rtl/aptl_div.sv
// Restoring divider, one quotient bit per cycle
module aptl_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [aptl_pkg::QUO_W-1:0]  dividend_i,
  input  logic [aptl_pkg::DUR_W-1:0]  divisor_i,
  output logic [aptl_pkg::QUO_W-1:0]  quo_o,
  output aptl_pkg::div_stat_t         stat_o
);

  localparam int QW   = aptl_pkg::QUO_W;
  localparam int DW   = aptl_pkg::DUR_W;
  localparam int CntW = $clog2(QW);
  localparam logic [CntW-1:0] CntLast = CntW'(QW - 1);

  logic [DW-1:0]   rem_q, rem_d;
  logic [QW-1:0]   quo_q, quo_d;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [DW:0]     trial;
  logic [DW+1:0]   diff;
  logic            ge;

  // Shift in the next dividend bit, subtract when the divisor fits
  always_comb begin
    trial = {rem_q, quo_q[QW-1]};
    diff  = {1'b0, trial} - {2'b00, divisor_i};
    ge    = ~diff[DW+1];
    rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
    quo_d = {quo_q[QW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quo_o       = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

### rtl/animation_progress_timeline.sv
// Animation timeline ramp generator: command decode, accumulator and result register
// Start, pause, rewind and ticks that need no division: result registered in the next cycle.
// Ticks with animations on and nonzero duration: the result passes through the 32-step
// divider, ST_DIV, ST_FIN and the result register; no request is taken until ST_IDLE.
// One request in flight at a time; the next request is taken as soon as the block is idle
// and the result register is free or being drained.
module animation_progress_timeline #(
  parameter int ACC_BITS = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [aptl_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [aptl_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  aptl_pkg::in_req_t                in_req_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output aptl_pkg::out_rsp_t               out_rsp_o
);

  `include "animation_progress_timeline_assert.svh"

  localparam int PW    = aptl_pkg::PROG_W;
  localparam int QW    = aptl_pkg::QUO_W;
  localparam int DW    = aptl_pkg::DUR_W;
  localparam int SumW  = ((ACC_BITS > QW + 1) ? ACC_BITS : (QW + 1)) + 1;

  localparam logic signed [ACC_BITS-1:0] AccMax = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] AccMin = {1'b1, {(ACC_BITS-1){1'b0}}};
  localparam logic signed [SumW-1:0]     SumMax = {{(SumW-ACC_BITS){1'b0}}, AccMax};
  localparam logic signed [SumW-1:0]     SumMin = {{(SumW-ACC_BITS){1'b1}}, AccMin};
  localparam logic [ACC_BITS-1:0]        AccOne = {{(ACC_BITS-PW){1'b0}}, aptl_pkg::PROG_ONE};

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [DW-1:0]       duration_q;
  logic                backward_q, loop_q, anim_on_q;
  logic                running_q, running_d;
  logic                anim_q, anim_d;
  logic [ACC_BITS-1:0] raw_q, raw_d;
  logic [PW-1:0]       shown_q, shown_d;
  logic                out_valid_q, out_valid_d;
  aptl_pkg::out_rsp_t  out_rsp_q, out_rsp_d, rsp;

  logic                in_fire;
  logic                div_start;
  logic [QW-1:0]       quo;
  aptl_pkg::div_stat_t div_stat;

  logic [PW-1:0]       end_val, start_val;
  logic [ACC_BITS-1:0] end_acc, start_acc;
  logic signed [SumW-1:0] raw_ext, delta_ext, sum;
  logic [ACC_BITS-1:0] sat_val, raw_cand;
  logic [PW-1:0]       clamp_val, fv;
  logic                tick_fin, load_out;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  aptl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({in_req_i.elapsed_ms, {aptl_pkg::FRAC_BITS{1'b0}}}),
    .divisor_i  (duration_q),
    .quo_o      (quo),
    .stat_o     (div_stat)
  );

  always_comb begin
    end_val   = backward_q ? aptl_pkg::PROG_ZERO : aptl_pkg::PROG_ONE;
    start_val = backward_q ? aptl_pkg::PROG_ONE : aptl_pkg::PROG_ZERO;
    end_acc   = {{(ACC_BITS-PW){1'b0}}, end_val};
    start_acc = {{(ACC_BITS-PW){1'b0}}, start_val};
  end

  // Accumulate the step and saturate at the accumulator width
  always_comb begin
    raw_ext   = {{(SumW-ACC_BITS){raw_q[ACC_BITS-1]}}, raw_q};
    delta_ext = {{(SumW-QW){1'b0}}, quo};
    sum       = backward_q ? (raw_ext - delta_ext) : (raw_ext + delta_ext);
    if (sum > SumMax) begin
      sat_val = AccMax;
    end else if (sum < SumMin) begin
      sat_val = AccMin;
    end else begin
      sat_val = sum[ACC_BITS-1:0];
    end
    if (sat_val[ACC_BITS-1]) begin
      clamp_val = aptl_pkg::PROG_ZERO;
    end else if (sat_val > AccOne) begin
      clamp_val = aptl_pkg::PROG_ONE;
    end else begin
      clamp_val = sat_val[PW-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    running_d   = running_q;
    anim_d      = anim_q;
    raw_d       = raw_q;
    shown_d     = shown_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_rsp_d   = out_rsp_q;
    div_start   = 1'b0;
    tick_fin    = 1'b0;
    load_out    = 1'b0;
    raw_cand    = raw_q;
    fv          = end_val;
    rsp             = '0;
    rsp.progress    = shown_q;
    rsp.running     = running_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          load_out = 1'b1;
          case (in_req_i.cmd)
            aptl_pkg::CMD_TICK: begin
              if (running_q) begin
                if (!anim_q) begin
                  tick_fin = 1'b1;
                end else if (duration_q == '0) begin
                  tick_fin = 1'b1;
                  raw_cand = end_acc;
                end else begin
                  div_start = 1'b1;
                  load_out  = 1'b0;
                  state_d   = ST_DIV;
                end
              end
            end
            aptl_pkg::CMD_START: begin
              if (!running_q) begin
                anim_d      = anim_on_q;
                running_d   = 1'b1;
                rsp.started = 1'b1;
                rsp.running = 1'b1;
              end
            end
            aptl_pkg::CMD_PAUSE: begin
              if (running_q) begin
                running_d   = 1'b0;
                rsp.paused  = 1'b1;
                rsp.running = 1'b0;
              end
            end
            aptl_pkg::CMD_REWIND: begin
              raw_d        = start_acc;
              shown_d      = start_val;
              rsp.progress = start_val;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        tick_fin = 1'b1;
        load_out = 1'b1;
        raw_cand = sat_val;
        fv       = clamp_val;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Report the frame value, then stop or rewind at the end
    if (tick_fin) begin
      raw_d           = raw_cand;
      shown_d         = fv;
      rsp.progress    = fv;
      rsp.frame_event = 1'b1;
      rsp.running     = 1'b1;
      if (fv == end_val) begin
        if (!loop_q) begin
          running_d    = 1'b0;
          rsp.finished = 1'b1;
          rsp.running  = 1'b0;
        end else begin
          raw_d   = start_acc;
          shown_d = start_val;
        end
      end
    end

    if (load_out) begin
      out_valid_d = 1'b1;
      out_rsp_d   = rsp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duration_q <= '0;
      backward_q <= 1'b0;
      loop_q     <= 1'b0;
      anim_on_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        aptl_pkg::REG_DURATION: duration_q <= cfg_wdata_i[DW-1:0];
        aptl_pkg::REG_BACKWARD: backward_q <= cfg_wdata_i[0];
        aptl_pkg::REG_LOOP:     loop_q     <= cfg_wdata_i[0];
        aptl_pkg::REG_ANIM_ON:  anim_on_q  <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      running_q   <= 1'b0;
      anim_q      <= 1'b0;
      raw_q       <= '0;
      shown_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      running_q   <= running_d;
      anim_q      <= anim_d;
      raw_q       <= raw_d;
      shown_q     <= shown_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rsp_q <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  `APT_ASSERT_IMPL(a_div_blocks_in, div_stat.busy, !in_ready_o, "request taken while dividing")
  `APT_ASSERT(a_shown_range, shown_q <= aptl_pkg::PROG_ONE, "shown progress above 1.0")
  `APT_ASSERT_IMPL(a_fin_stops, out_valid_o && out_rsp_o.finished,
                   !out_rsp_o.running && out_rsp_o.frame_event, "finished while running")

endmodule

### verif/tb.sv
// Testbench for the animation timeline ramp generator: directed and random commands
`timescale 1ns / 100ps

module tb;

  localparam int     ACC_W       = 24;
  localparam longint ACC_HI      = (longint'(1) << (ACC_W - 1)) - 1;
  localparam longint ACC_LO      = -(longint'(1) << (ACC_W - 1));
  localparam longint ONE_L       = longint'(1) << aptl_pkg::FRAC_BITS;
  localparam int     PW          = aptl_pkg::PROG_W;
  localparam int     LATENCY     = 40;
  localparam int     HOLD_CYCLES = 300;
  localparam int     CYCLE_LIMIT = 400000;

  logic                            clk_i;
  logic                            rst_ni      = 1'b0;
  logic                            cfg_we_i    = 1'b0;
  logic [aptl_pkg::CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [aptl_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_ready_o;
  aptl_pkg::in_req_t               in_req_i    = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  aptl_pkg::out_rsp_t              out_rsp_o;

  // mirrored registers
  logic [aptl_pkg::DUR_W-1:0] dur_q     = '0;
  logic                       back_q    = 1'b0;
  logic                       loop_q    = 1'b0;
  logic                       anim_on_q = 1'b0;

  // mirrored timeline
  logic              run_q     = 1'b0;
  logic              anim_q    = 1'b0;
  longint            acc_q     = 0;
  logic [PW-1:0]     shown_q   = aptl_pkg::PROG_ZERO;

  aptl_pkg::out_rsp_t pending_rsp_q[$];
  int                errors    = 0;
  int                cycles    = 0;
  logic              quiet     = 1'b0;
  logic              hold_tog  = 1'b0;
  logic              hold_seen = 1'b0;
  int                hold_left = 0;
  int                stall_left = 0;

  animation_progress_timeline #(.ACC_BITS(ACC_W)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void rewind_timeline();
    acc_q   = back_q ? ONE_L : 0;
    shown_q = back_q ? aptl_pkg::PROG_ONE : aptl_pkg::PROG_ZERO;
  endfunction

  function automatic aptl_pkg::out_rsp_t advance_timeline(aptl_pkg::in_req_t r);
    aptl_pkg::out_rsp_t rsp;
    longint             step;
    logic [PW-1:0]      fv;
    rsp = '0;
    rsp.progress = shown_q;
    case (r.cmd)
      aptl_pkg::CMD_TICK: begin
        if (run_q) begin
          if (anim_q) begin
            if (dur_q == '0) begin
              acc_q = back_q ? 0 : ONE_L;
            end else begin
              step  = (longint'(r.elapsed_ms) << aptl_pkg::FRAC_BITS) / longint'(dur_q);
              acc_q = back_q ? acc_q - step : acc_q + step;
              if (acc_q > ACC_HI) acc_q = ACC_HI;
              else if (acc_q < ACC_LO) acc_q = ACC_LO;
            end
            if (acc_q < 0) fv = aptl_pkg::PROG_ZERO;
            else if (acc_q > ONE_L) fv = aptl_pkg::PROG_ONE;
            else fv = acc_q[PW-1:0];
          end else begin
            fv = back_q ? aptl_pkg::PROG_ZERO : aptl_pkg::PROG_ONE;
          end
          shown_q = fv;
          rsp.progress = fv;
          rsp.frame_event = 1'b1;
          // report the frame value first, then loop or stop
          if (fv == (back_q ? aptl_pkg::PROG_ZERO : aptl_pkg::PROG_ONE)) begin
            if (loop_q) begin
              rewind_timeline();
            end else begin
              run_q = 1'b0;
              rsp.finished = 1'b1;
            end
          end
        end
      end
      aptl_pkg::CMD_START: begin
        if (!run_q) begin
          anim_q = anim_on_q;
          run_q = 1'b1;
          rsp.started = 1'b1;
        end
      end
      aptl_pkg::CMD_PAUSE: begin
        if (run_q) begin
          run_q = 1'b0;
          rsp.paused = 1'b1;
        end
      end
      default: begin
        rewind_timeline();
        rsp.progress = shown_q;
      end
    endcase
    rsp.running = run_q;
    return rsp;
  endfunction

  task automatic check_field(string name, logic [PW-1:0] want, logic [PW-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : rsp_check
    aptl_pkg::out_rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rsp_q.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending, expected none, actual %p",
                 $time, out_rsp_o);
      end else begin
        want = pending_rsp_q.pop_front();
        check_field("progress", want.progress, out_rsp_o.progress);
        check_field("frame_event", PW'(want.frame_event), PW'(out_rsp_o.frame_event));
        check_field("finished", PW'(want.finished), PW'(out_rsp_o.finished));
        check_field("started", PW'(want.started), PW'(out_rsp_o.started));
        check_field("paused", PW'(want.paused), PW'(out_rsp_o.paused));
        check_field("running", PW'(want.running), PW'(out_rsp_o.running));
      end
    end
  end

  always @(posedge clk_i) begin : rsp_ready
    int gap;
    if (hold_tog != hold_seen) begin
      hold_seen   <= hold_tog;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      gap = quiet ? 0 : pick_gap();
      out_ready_i <= (gap == 0);
      if (gap > 0) stall_left <= gap - 1;
    end
  end

  task automatic send_cmd(aptl_pkg::cmd_e c, logic [aptl_pkg::ELAPSED_W-1:0] ms);
    aptl_pkg::in_req_t r;
    int                gap;
    r.cmd = c;
    r.elapsed_ms = ms;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
    pending_rsp_q.push_back(advance_timeline(r));
  endtask

  // drop valid, wait for every result, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic set_cfg(logic [aptl_pkg::DUR_W-1:0] dur, logic back, logic lp, logic anim);
    aptl_pkg::cfg_idx_e order[4] = '{aptl_pkg::REG_DURATION, aptl_pkg::REG_BACKWARD,
                                     aptl_pkg::REG_LOOP, aptl_pkg::REG_ANIM_ON};
    logic [aptl_pkg::CFG_DATA_W-1:0] wdata[4];
    drain();
    wdata[0] = dur;
    // random upper bits on the one-bit registers must be ignored
    wdata[1] = aptl_pkg::CFG_DATA_W'($urandom);
    wdata[1][0] = back;
    wdata[2] = aptl_pkg::CFG_DATA_W'($urandom);
    wdata[2][0] = lp;
    wdata[3] = aptl_pkg::CFG_DATA_W'($urandom);
    wdata[3][0] = anim;
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= order[i];
      cfg_wdata_i <= wdata[i];
      @(posedge clk_i);
    end
    cfg_we_i  <= 1'b0;
    dur_q     = dur;
    back_q    = back;
    loop_q    = lp;
    anim_on_q = anim;
  endtask

  task automatic test_commands();
    set_cfg(20'd1000, 1'b0, 1'b0, 1'b1);
    send_cmd(aptl_pkg::CMD_TICK, 16'hFFFF);   // idle, ignored
    send_cmd(aptl_pkg::CMD_PAUSE, 16'h0000);  // idle, ignored
    send_cmd(aptl_pkg::CMD_START, 16'h0000);
    send_cmd(aptl_pkg::CMD_START, 16'hFFFF);  // already running
    send_cmd(aptl_pkg::CMD_TICK, 16'd0);
    send_cmd(aptl_pkg::CMD_TICK, 16'd500);
    send_cmd(aptl_pkg::CMD_PAUSE, 16'd0);
    send_cmd(aptl_pkg::CMD_TICK, 16'd7);
    send_cmd(aptl_pkg::CMD_START, 16'd0);
    send_cmd(aptl_pkg::CMD_REWIND, 16'hAAAA);
    send_cmd(aptl_pkg::CMD_TICK, 16'hFFFF);   // overshoot, finish
  endtask

  task automatic test_saturation();
    set_cfg(20'd1, 1'b0, 1'b1, 1'b1);
    send_cmd(aptl_pkg::CMD_START, 16'd0);
    send_cmd(aptl_pkg::CMD_TICK, 16'hFFFF);   // clip high, loop back
    set_cfg(20'd1, 1'b0, 1'b0, 1'b1);
    send_cmd(aptl_pkg::CMD_START, 16'd0);
    send_cmd(aptl_pkg::CMD_TICK, 16'hFFFF);
    set_cfg(20'd1, 1'b1, 1'b0, 1'b1);
    send_cmd(aptl_pkg::CMD_START, 16'd0);
    send_cmd(aptl_pkg::CMD_TICK, 16'h0010);   // still far above 1.0
    send_cmd(aptl_pkg::CMD_TICK, 16'hFFFF);   // clip low
  endtask

  task automatic test_jump_to_end();
    set_cfg('0, 1'b0, 1'b0, 1'b0);
    send_cmd(aptl_pkg::CMD_START, 16'd0);
    send_cmd(aptl_pkg::CMD_TICK, 16'd0);
    set_cfg('0, 1'b1, 1'b1, 1'b1);
    send_cmd(aptl_pkg::CMD_START, 16'd0);
    send_cmd(aptl_pkg::CMD_TICK, 16'd9);
    send_cmd(aptl_pkg::CMD_REWIND, 16'd0);
    send_cmd(aptl_pkg::CMD_PAUSE, 16'd0);
  endtask

  task automatic test_random_ramps();
    logic [aptl_pkg::DUR_W-1:0]     dur;
    logic [aptl_pkg::ELAPSED_W-1:0] ms;
    aptl_pkg::cmd_e                 c;
    int                             r;
    for (int ph = 0; ph < 14; ph++) begin
      r = $urandom_range(0, 9);
      if (ph == 0) dur = '1;
      else if (ph == 1) dur = '0;
      else if (r == 0) dur = '0;
      else if (r == 1) dur = 20'd1;
      else if (r == 2) dur = '1;
      else if (r == 3) dur = aptl_pkg::DUR_W'($urandom);
      else dur = aptl_pkg::DUR_W'($urandom_range(20, 4000));
      set_cfg(dur, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              $urandom_range(0, 3) != 0);
      quiet = (ph % 4 == 3);
      for (int n = 0; n < 50; n++) begin
        r = $urandom_range(0, 99);
        if (!run_q && r < 60) c = aptl_pkg::CMD_START;
        else if (r < 70) c = aptl_pkg::CMD_TICK;
        else if (r < 80) c = aptl_pkg::CMD_START;
        else if (r < 90) c = aptl_pkg::CMD_PAUSE;
        else c = aptl_pkg::CMD_REWIND;
        r = $urandom_range(0, 99);
        if (r < 65) ms = aptl_pkg::ELAPSED_W'($urandom_range(0, 64));
        else if (r < 85) ms = aptl_pkg::ELAPSED_W'($urandom_range(0, 2000));
        else if (r < 92) ms = '1;
        else if (r < 96) ms = '0;
        else ms = aptl_pkg::ELAPSED_W'($urandom);
        send_cmd(c, ms);
      end
    end
    quiet = 1'b0;
  endtask

  // hold the result side off while requests keep coming
  task automatic test_backpressure();
    set_cfg(20'd3000, 1'b0, 1'b1, 1'b1);
    quiet = 1'b1;
    hold_tog = ~hold_tog;
    send_cmd(aptl_pkg::CMD_START, 16'd0);
    for (int n = 0; n < 15; n++) begin
      send_cmd(aptl_pkg::CMD_TICK, aptl_pkg::ELAPSED_W'($urandom_range(0, 400)));
    end
    send_cmd(aptl_pkg::CMD_PAUSE, 16'd0);
    send_cmd(aptl_pkg::CMD_REWIND, 16'd0);
    quiet = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_commands();
    test_saturation();
    test_jump_to_end();
    test_random_ramps();
    test_backpressure();
    drain();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
